// ===== rtl/core/emie_pkg.sv =====
package emie_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned INDEX_W = 11;
    localparam int unsigned ROUNDS  = 64;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic load_byte;
        logic hash_start;
        logic round_step;
        logic hash_finish;
        logic emit_step;
        logic emit_clear;
    } t_cmd;

    typedef struct packed {
        logic round_last;
        logic emit_last;
    } t_status;

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

// ===== rtl/core/emie_ctrl.sv =====
module emie_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  logic              i_cfg_we,
    input  logic              i_load_done,
    input  emie_pkg::t_status i_status,
    output emie_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_INIT,
        S_ROUND,
        S_FINISH,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    logic in_take, out_take;

    assign o_stall  = (r_state != S_LOAD);
    assign o_valid  = (r_state == S_EMIT);
    assign in_take  = i_valid && !o_stall;
    assign out_take = o_valid && !i_stall;

    always_comb begin
        o_cmd = '0;
        o_cmd.load_byte   = in_take;
        o_cmd.hash_start  = (r_state == S_INIT);
        o_cmd.round_step  = (r_state == S_ROUND);
        o_cmd.hash_finish = (r_state == S_FINISH);
        o_cmd.emit_step   = out_take;
        o_cmd.emit_clear  = i_cfg_we;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:   if (in_take && i_load_done && !i_cfg_we) n_state = S_INIT;
            S_INIT:   n_state = S_ROUND;
            S_ROUND:  if (i_status.round_last) n_state = S_FINISH;
            S_FINISH: n_state = S_EMIT;
            S_EMIT:   if (out_take && i_status.emit_last) n_state = S_LOAD;
            default:  n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !in_take)
        else $error("input taken while busy");
    a_round_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && i_status.round_last) |=> (r_state == S_FINISH))
        else $error("round end missed");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");

endmodule

// ===== rtl/core/emie_dp.sv =====
module emie_dp #(
    parameter int unsigned MAX_ENTROPY_BYTES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [3:0]                     i_entropy_words,
    input  logic [7:0]                     i_entropy_byte,
    input  emie_pkg::t_cmd                 i_cmd,
    output logic                           o_load_done,
    output emie_pkg::t_status              o_status,
    output logic [emie_pkg::INDEX_W-1:0]   o_word_index,
    output logic                           o_last_word
);

    localparam int unsigned CAP_RAW = MAX_ENTROPY_BYTES / 4;
    localparam int unsigned CAP     = (CAP_RAW > 8) ? 8 : CAP_RAW;
    localparam int unsigned BITS    = 8 * 32 + 8;
    localparam int unsigned POS_W   = $clog2(BITS);

    logic [3:0] words;
    logic [5:0] nbytes;
    logic [4:0] nidx;

    always_comb begin
        words = i_entropy_words;
        if (words < 4'd4) words = 4'd4;
        if (words > 4'(CAP)) words = 4'(CAP);
        nbytes = {words, 2'b00};
        nidx   = 5'(words * 3);
    end

    logic [5:0] r_bytes_loaded;
    logic [7:0] r_ent [32];
    logic [BITS-1:0] r_bits;
    emie_pkg::t_word r_h [8];
    emie_pkg::t_word r_v [8];
    emie_pkg::t_word r_w [16];
    logic [5:0] r_round;
    logic [POS_W-1:0] r_pos;
    logic [4:0] r_emit;

    assign o_load_done = (r_bytes_loaded + 6'd1 == nbytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_loaded <= '0;
        end else if (i_cmd.emit_clear) begin
            r_bytes_loaded <= '0;
        end else if (i_cmd.load_byte) begin
            r_bytes_loaded <= o_load_done ? 6'd0 : r_bytes_loaded + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) r_ent[r_bytes_loaded[4:0]] <= i_entropy_byte;
    end

    emie_pkg::t_word wt, g0, g1, s0, s1, ch, maj, t1, t2, wa, wb;

    always_comb begin
        wa = r_w[1];
        wb = r_w[14];
        g0 = emie_pkg::rotr(wa, 7) ^ emie_pkg::rotr(wa, 18) ^ (wa >> 3);
        g1 = emie_pkg::rotr(wb, 17) ^ emie_pkg::rotr(wb, 19) ^ (wb >> 10);
        wt = r_w[0];
        s1 = emie_pkg::rotr(r_v[4], 6) ^ emie_pkg::rotr(r_v[4], 11)
           ^ emie_pkg::rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + emie_pkg::ROUND_K[r_round] + wt;
        s0 = emie_pkg::rotr(r_v[0], 2) ^ emie_pkg::rotr(r_v[0], 13)
           ^ emie_pkg::rotr(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = s0 + maj;
    end

    assign o_status.round_last = (r_round == 6'(emie_pkg::ROUNDS - 1));
    assign o_status.emit_last  = (r_emit + 5'd1 == nidx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
            r_emit  <= '0;
            r_pos   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= emie_pkg::INIT_H[i];
        end else begin
            if (i_cmd.hash_start) begin
                r_round <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= emie_pkg::INIT_H[i];
                    r_h[i] <= emie_pkg::INIT_H[i];
                end
                for (int i = 0; i < 15; i++) begin
                    for (int b = 0; b < 4; b++) begin
                        if (4 * i + b < 32 && 6'(4 * i + b) < nbytes)
                            r_w[i][31-8*b -: 8] <= r_ent[5'(4 * i + b)];
                        else if (6'(4 * i + b) == nbytes)
                            r_w[i][31-8*b -: 8] <= 8'h80;
                        else
                            r_w[i][31-8*b -: 8] <= 8'h00;
                    end
                end
                r_w[15] <= {23'd0, nbytes, 3'd0};
                for (int i = 0; i < 32; i++) begin
                    r_bits[BITS-1-8*i -: 8] <= r_ent[i];
                end
            end
            if (i_cmd.round_step) begin
                r_round <= r_round + 6'd1;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= r_w[0] + g0 + g1 + r_w[9];
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            if (i_cmd.hash_finish) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                r_bits[BITS-1-8*nbytes -: 8] <= 8'(((r_h[0] + r_v[0]) >> 24));
                r_emit <= '0;
                r_pos  <= '0;
            end
            if (i_cmd.emit_step) begin
                r_emit <= r_emit + 5'd1;
                r_pos  <= r_pos + POS_W'(emie_pkg::INDEX_W);
            end
        end
    end

    assign o_word_index = r_bits[BITS-1-r_pos -: emie_pkg::INDEX_W];
    assign o_last_word  = o_status.emit_last;

endmodule

// ===== rtl/core/entropy_to_mnemonic_index_encoder.sv =====
// Loads 4*N entropy bytes, one per cycle (N = entropy_words, 4..8).
// After the last byte: a setup state, 64 SHA-256 rounds, a finish state,
// then 3*N indices, one per cycle while not stalled.
// Input stays stalled until the last index is taken; one round per cycle.
// Reset (synchronous, active low): register = 4, load count cleared, idle.
module entropy_to_mnemonic_index_encoder #(
    parameter int unsigned MAX_ENTROPY_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_entropy_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_word_index,
    output logic        o_last_word
);

    logic [3:0] r_entropy_words;
    logic load_done;
    emie_pkg::t_cmd cmd;
    emie_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entropy_words <= 4'd4;
        end else if (i_cfg_we) begin
            r_entropy_words <= i_cfg_wdata;
        end
    end

    emie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_load_done (load_done),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    emie_dp #(.MAX_ENTROPY_BYTES(MAX_ENTROPY_BYTES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entropy_words (r_entropy_words),
        .i_entropy_byte  (i_entropy_byte),
        .i_cmd           (cmd),
        .o_load_done     (load_done),
        .o_status        (status),
        .o_word_index    (o_word_index),
        .o_last_word     (o_last_word)
    );

endmodule

// ===== test/mnemonic_index_checker.sv =====
module mnemonic_index_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_entropy_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [10:0] i_word_index,
    input  logic        i_last_word,
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [10:0] word_index;
        logic        last_word;
    } t_index_word;

    t_index_word expected_words[$];
    logic [7:0]  entropy_bytes[32];
    logic [3:0]  word_count_reg;
    int          loaded;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic int clamp_words(logic [3:0] v);
        if (v < 4) return 4;
        if (v > 8) return 8;
        return int'(v);
    endfunction

    function automatic logic [7:0] checksum_byte(int nbytes);
        logic [7:0]  blk[64];
        logic [31:0] sched[16];
        logic [31:0] v[8];
        logic [31:0] a, b, t1, t2;
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        for (int i = 0; i < nbytes; i++) blk[i] = entropy_bytes[i];
        blk[nbytes] = 8'h80;
        blk[62] = 8'((nbytes * 8) >> 8);
        blk[63] = 8'(nbytes * 8);
        for (int i = 0; i < 16; i++)
            sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 0; i < 8; i++) v[i] = emie_pkg::INIT_H[i];
        for (int t = 0; t < 64; t++) begin
            if (t >= 16) begin
                a = sched[(t - 15) & 15];
                b = sched[(t - 2) & 15];
                sched[t & 15] += (ror(a, 7) ^ ror(a, 18) ^ (a >> 3))
                    + (ror(b, 17) ^ ror(b, 19) ^ (b >> 10)) + sched[(t - 7) & 15];
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + emie_pkg::ROUND_K[t] + sched[t & 15];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        return 8'((emie_pkg::INIT_H[0] + v[0]) >> 24);
    endfunction

    task automatic predict_mnemonic(int words);
        logic [0:263] stream;
        t_index_word  w;
        stream = '0;
        for (int i = 0; i < words * 4; i++) stream[i*8 +: 8] = entropy_bytes[i];
        stream[words*32 +: 8] = checksum_byte(words * 4);
        for (int i = 0; i < words * 3; i++) begin
            w.word_index = stream[i*11 +: 11];
            w.last_word  = (i == words * 3 - 1);
            expected_words.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        t_index_word w;
        if (!i_rst_n) begin
            word_count_reg = 4'd4;
            loaded = 0;
        end else begin
            if (i_cfg_we) begin
                word_count_reg = i_cfg_wdata;
                loaded = 0;
            end
            if (i_in_valid && !i_in_stall) begin
                entropy_bytes[loaded] = i_entropy_byte;
                loaded++;
                if (loaded == clamp_words(word_count_reg) * 4) begin
                    loaded = 0;
                    predict_mnemonic(clamp_words(word_count_reg));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("unexpected transaction: index %0d last %0b",
                                 i_word_index, i_last_word);
                end else begin
                    w = expected_words.pop_front();
                    if (w.word_index !== i_word_index || w.last_word !== i_last_word) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("mismatch: expected index %0d last %0b, got %0d %0b",
                                     w.word_index, w.last_word, i_word_index, i_last_word);
                    end
                end
            end
        end
        o_pending = expected_words.size();
    end
endmodule

// ===== test/entropy_to_mnemonic_index_encoder_test.sv =====
module entropy_to_mnemonic_index_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = 4'd0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_entropy_byte = 8'd0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [10:0] o_word_index;
    logic        o_last_word;

    int          mismatches;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          quiet_cycles = 0;
    logic [3:0]  cur_cfg = 4'd4;
    logic [3:0]  cfg_plan[9] = '{4'd8, 4'd0, 4'd5, 4'd15, 4'd6, 4'd3, 4'd7, 4'd4, 4'd8};

    entropy_to_mnemonic_index_encoder dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_valid, .o_stall, .i_entropy_byte,
        .o_valid, .i_stall, .o_word_index, .o_last_word
    );

    mnemonic_index_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_entropy_byte,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_word_index(o_word_index), .i_last_word(o_last_word),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_entropy_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [3:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        cur_cfg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int mnemonic_bytes(logic [3:0] v);
        return (v < 4) ? 16 : (v > 8) ? 32 : 4 * int'(v);
    endfunction

    initial begin
        int sent;
        tx_idle_pct = 10;
        rx_idle_pct = 52;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-ones entropy at reset word count, then a partial load dropped by a write
        repeat (16) send_byte(8'hff);
        repeat (5) send_byte(8'h00);
        write_cfg(4'd0);
        repeat (16) send_byte(8'h00);

        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 10 : (p == 1) ? 52 : 0;
            rx_idle_pct = (p == 0) ? 52 : (p == 1) ? 10 : 0;
            for (int c = p * 3; c < p * 3 + 3; c++) begin
                write_cfg(cfg_plan[c]);
                sent = 0;
                while (sent < 16) begin
                    repeat (mnemonic_bytes(cur_cfg)) send_byte(8'($urandom));
                    sent += mnemonic_bytes(cur_cfg);
                end
                if ($urandom_range(1)) repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end
        drain();
        if (mismatches + pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
